// File: rtl/clctq_pkg.sv
// Shared types, sizes and codes for the clustered timed work queue.
// No dependencies.
package clctq_pkg;

    localparam int MAX_CLUSTERS = 8;
    localparam int QUEUE_DEPTH  = 64;
    localparam int CL_BITS      = $clog2(MAX_CLUSTERS);
    localparam int Q_BITS       = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS     = Q_BITS + 1;
    localparam int SLOTS        = MAX_CLUSTERS * QUEUE_DEPTH;
    localparam int ADDR_BITS    = CL_BITS + Q_BITS;
    localparam int TOTAL_BITS   = 11;
    localparam int PAY_BITS     = 32;
    localparam int TIME_BITS    = 32;
    localparam int ENTRY_BITS   = PAY_BITS + TIME_BITS;
    localparam int DIV_BITS     = 16;
    localparam int REG_BITS     = 7;

    typedef enum logic [1:0] {
        REQ_PUT  = 2'd0,
        REQ_GET  = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NOP  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_DROPPED  = 2'd2,
        ST_BAD_CORE = 2'd3
    } t_status;

    localparam logic [1:0] CFG_NUM_CORES    = 2'd0;
    localparam logic [1:0] CFG_CLUSTER_SIZE = 2'd1;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [5:0]           core_index;
        logic [15:0]          random_draw;
        logic [PAY_BITS-1:0]  work_payload;
        logic [TIME_BITS-1:0] ready_time;
    } t_in_item;

    typedef struct packed {
        logic                  got_work;
        logic [PAY_BITS-1:0]   out_payload;
        logic [TIME_BITS-1:0]  out_ready_time;
        logic [1:0]            status;
        logic                  work_available;
        logic                  any_pending;
        logic [TOTAL_BITS-1:0] total_count;
        logic [TIME_BITS-1:0]  current_time;
    } t_out_item;

    typedef struct packed {
        logic [PAY_BITS-1:0]  payload;
        logic [TIME_BITS-1:0] when;
    } t_entry;

    // front to back handoff
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_front_out;

endpackage

// File: rtl/clctq_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module clctq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/clctq_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on clctq_pkg.
module clctq_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [clctq_pkg::DIV_BITS-1:0]     i_dividend,
    input  logic [clctq_pkg::REG_BITS-1:0]     i_divisor,
    output logic                               o_done,
    output logic [clctq_pkg::DIV_BITS-1:0]     o_quot,
    output logic [clctq_pkg::REG_BITS-1:0]     o_rem
);

    localparam int CB = $clog2(clctq_pkg::DIV_BITS + 1);

    logic                              r_busy;
    logic                              r_done;
    logic [CB-1:0]                     r_cnt;
    logic [clctq_pkg::REG_BITS:0]      r_rem;
    logic [clctq_pkg::DIV_BITS-1:0]    r_quot;
    logic [clctq_pkg::REG_BITS-1:0]    r_div;
    logic [clctq_pkg::REG_BITS+1:0]    rem_sh;
    logic                              fits;

    always_comb begin
        rem_sh = {r_rem, r_quot[clctq_pkg::DIV_BITS-1]};
        fits   = rem_sh >= {2'b00, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CB'(clctq_pkg::DIV_BITS);
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= fits ? (clctq_pkg::REG_BITS+1)'(rem_sh - {2'b00, r_div})
                               : rem_sh[clctq_pkg::REG_BITS:0];
                r_quot <= {r_quot[clctq_pkg::DIV_BITS-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CB'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[clctq_pkg::REG_BITS-1:0];

endmodule

// File: rtl/clctq_front.sv
// Front end: accepts request transfers into a two-entry queue for the engine.
// Depends on clctq_pkg.
module clctq_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  clctq_pkg::t_in_item   i_in_item,
    output clctq_pkg::t_front_out o_front,
    input  logic                  i_pop
);

    clctq_pkg::t_in_item r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push = i_in_valid && !o_in_stall;
    assign pop  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assign o_front.valid = (r_cnt != 2'd0);
    assign o_front.item  = r_q[r_rp];

endmodule

// File: rtl/clctq_back.sv
// Back end: sequencer that runs puts, gets and ticks on the two stores.
// Depends on clctq_pkg, clctq_ram and clctq_div.
module clctq_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  clctq_pkg::t_front_out                i_front,
    output logic                                 o_pop,
    input  logic [clctq_pkg::REG_BITS-1:0]       i_num_cores,
    input  logic [clctq_pkg::REG_BITS-1:0]       i_cluster_size,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output clctq_pkg::t_out_item                 o_out_item
);

    localparam int NC = clctq_pkg::MAX_CLUSTERS;
    localparam int CB = clctq_pkg::CL_BITS;
    localparam int QB = clctq_pkg::Q_BITS;
    localparam int NB = clctq_pkg::CNT_BITS;
    localparam int AB = CB + 1;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_ACT  = 14'b00000000000010,
        S_MOD  = 14'b00000000000100,
        S_CLU  = 14'b00000000001000,
        S_PUT  = 14'b00000000010000,
        S_GRD  = 14'b00000000100000,
        S_GOUT = 14'b00000001000000,
        S_CHK  = 14'b00000010000000,
        S_SRD  = 14'b00000100000000,
        S_SCMP = 14'b00001000000000,
        S_DEC  = 14'b00010000000000,
        S_HRD  = 14'b00100000000000,
        S_HWR  = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } t_state;

    t_state                                  r_state;
    clctq_pkg::t_in_item                     r_item;
    clctq_pkg::t_out_item                    r_res;
    clctq_pkg::t_out_item                    r_out;
    logic                                    r_out_vld;
    logic [clctq_pkg::TIME_BITS-1:0]         r_time;
    logic [clctq_pkg::TOTAL_BITS-1:0]        r_total;
    logic [QB-1:0]                           r_head [NC];
    logic [NB-1:0]                           r_fcnt [NC];
    logic [NB-1:0]                           r_pcnt [NC];
    logic [AB-1:0]                           r_act;
    logic [clctq_pkg::REG_BITS-1:0]          r_rem;
    logic [AB-1:0]                           r_c;
    logic [QB-1:0]                           r_i;
    logic [QB-1:0]                           r_j;
    logic [QB-1:0]                           r_best_idx;
    clctq_pkg::t_entry                       r_best;
    logic                                    r_div_issued;

    logic [clctq_pkg::REG_BITS-1:0]          ec;
    logic [clctq_pkg::REG_BITS-1:0]          es;
    logic                                    div_start;
    logic [clctq_pkg::DIV_BITS-1:0]          div_dividend;
    logic [clctq_pkg::REG_BITS-1:0]          div_divisor;
    logic                                    div_done;
    logic [clctq_pkg::DIV_BITS-1:0]          div_quot;
    logic [clctq_pkg::REG_BITS-1:0]          div_rem;
    logic [CB-1:0]                           ci;
    logic [NB-1:0]                           n_cur;
    logic [NB-1:0]                           f_cur;
    logic [AB-1:0]                           q_act;
    logic [CB-1:0]                           q_cl;
    logic                                    q_big;
    logic                                    avail;
    clctq_pkg::t_out_item                    res_full;

    logic                                    p_we;
    logic [clctq_pkg::ADDR_BITS-1:0]         p_waddr;
    clctq_pkg::t_entry                       p_wdata;
    logic [clctq_pkg::ADDR_BITS-1:0]         p_raddr;
    clctq_pkg::t_entry                       p_rdata;
    logic                                    f_we;
    logic [clctq_pkg::ADDR_BITS-1:0]         f_waddr;
    clctq_pkg::t_entry                       f_wdata;
    logic [clctq_pkg::ADDR_BITS-1:0]         f_raddr;
    clctq_pkg::t_entry                       f_rdata;

    assign ec = (i_num_cores == '0) ? clctq_pkg::REG_BITS'(1) : i_num_cores;
    assign es = (i_cluster_size == '0) ? clctq_pkg::REG_BITS'(1) : i_cluster_size;
    assign ci = r_c[CB-1:0];
    assign n_cur = r_pcnt[ci];
    assign f_cur = r_fcnt[ci];

    // divider use per state: active cluster count, draw mod cores, cluster index
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = es;
        unique case (r_state)
            S_ACT: begin
                div_start    = !r_div_issued;
                div_dividend = clctq_pkg::DIV_BITS'(ec);
            end
            S_MOD: begin
                div_start    = !r_div_issued;
                div_dividend = r_item.random_draw;
                div_divisor  = ec;
            end
            S_CLU: begin
                div_start    = !r_div_issued;
                div_dividend = (r_item.req_type == clctq_pkg::REQ_PUT)
                             ? clctq_pkg::DIV_BITS'(r_rem)
                             : clctq_pkg::DIV_BITS'(r_item.core_index);
            end
            default: ;
        endcase
    end

    always_comb begin
        if (div_quot == '0) begin
            q_act = AB'(1);
        end else if (div_quot > clctq_pkg::DIV_BITS'(NC)) begin
            q_act = AB'(NC);
        end else begin
            q_act = div_quot[AB-1:0];
        end
        q_big = div_quot >= clctq_pkg::DIV_BITS'(r_act);
        q_cl  = q_big ? CB'(r_act - 1'b1) : div_quot[CB-1:0];
    end

    clctq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        p_we    = 1'b0;
        p_waddr = {ci, r_j};
        p_wdata = p_rdata;
        if (r_state == S_PUT && n_cur < NB'(clctq_pkg::QUEUE_DEPTH)) begin
            p_we    = 1'b1;
            p_waddr = {ci, n_cur[QB-1:0]};
            p_wdata = {r_item.work_payload, r_item.ready_time};
        end else if (r_state == S_HWR) begin
            p_we = 1'b1;
        end
        p_raddr = (r_state == S_HRD) ? {ci, QB'(r_j + 1'b1)} : {ci, r_i};
        f_we    = (r_state == S_DEC) && (r_best.when <= r_time);
        f_waddr = {ci, QB'(r_head[ci] + f_cur[QB-1:0])};
        f_wdata = r_best;
        f_raddr = {ci, r_head[ci]};
    end

    clctq_ram #(.WIDTH(clctq_pkg::ENTRY_BITS), .DEPTH(clctq_pkg::SLOTS)) u_pend (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    clctq_ram #(.WIDTH(clctq_pkg::ENTRY_BITS), .DEPTH(clctq_pkg::SLOTS)) u_fifo (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    always_comb begin
        avail = 1'b0;
        for (int k = 0; k < NC; k++) begin
            if (r_fcnt[k] != '0) avail = 1'b1;
        end
    end

    assign o_pop = (r_state == S_IDLE) && i_front.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_vld    <= 1'b0;
            r_time       <= '0;
            r_total      <= '0;
            r_div_issued <= 1'b0;
            for (int k = 0; k < NC; k++) begin
                r_head[k] <= '0;
                r_fcnt[k] <= '0;
                r_pcnt[k] <= '0;
            end
        end else begin
            if (r_state == S_DONE && (!r_out_vld || !i_out_stall)) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (div_start) r_div_issued <= 1'b1;
            if (div_done)  r_div_issued <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_front.valid) begin
                        r_item <= i_front.item;
                        r_res  <= '0;
                        r_state <= (i_front.item.req_type == clctq_pkg::REQ_NOP)
                                 ? S_DONE : S_ACT;
                    end
                end
                S_ACT: begin
                    if (div_done) begin
                        r_act <= q_act;
                        unique case (r_item.req_type)
                            clctq_pkg::REQ_PUT: r_state <= S_MOD;
                            clctq_pkg::REQ_GET: r_state <= S_CLU;
                            default: begin
                                r_time  <= r_time + 1'b1;
                                r_c     <= '0;
                                r_state <= S_CHK;
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    if (div_done) begin
                        r_rem   <= div_rem;
                        r_state <= S_CLU;
                    end
                end
                S_CLU: begin
                    if (div_done) begin
                        r_c <= {1'b0, q_cl};
                        if (r_item.req_type == clctq_pkg::REQ_PUT) begin
                            r_state <= S_PUT;
                        end else if ({1'b0, r_item.core_index} >= ec || q_big) begin
                            r_res.status <= clctq_pkg::ST_BAD_CORE;
                            r_state <= S_DONE;
                        end else if (r_fcnt[q_cl] == '0) begin
                            r_res.status <= clctq_pkg::ST_EMPTY;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_GRD;
                        end
                    end
                end
                S_PUT: begin
                    if (n_cur >= NB'(clctq_pkg::QUEUE_DEPTH)) begin
                        r_res.status <= clctq_pkg::ST_DROPPED;
                    end else begin
                        r_pcnt[ci] <= n_cur + 1'b1;
                        r_total    <= r_total + 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_GRD: r_state <= S_GOUT;
                S_GOUT: begin
                    r_res.got_work       <= 1'b1;
                    r_res.out_payload    <= f_rdata.payload;
                    r_res.out_ready_time <= f_rdata.when;
                    r_head[ci] <= r_head[ci] + 1'b1;
                    r_fcnt[ci] <= f_cur - 1'b1;
                    r_total    <= r_total - 1'b1;
                    r_state    <= S_DONE;
                end
                S_CHK: begin
                    if (r_c >= r_act) begin
                        r_state <= S_DONE;
                    end else if (n_cur != '0 && f_cur < NB'(clctq_pkg::QUEUE_DEPTH)) begin
                        r_i     <= '0;
                        r_state <= S_SRD;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_SRD: r_state <= S_SCMP;
                S_SCMP: begin
                    // strict compare keeps the earliest arrival among equal times
                    if (r_i == '0 || p_rdata.when < r_best.when) begin
                        r_best     <= p_rdata;
                        r_best_idx <= r_i;
                    end
                    if ({1'b0, r_i} + 1'b1 == n_cur) begin
                        r_state <= S_DEC;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_DEC: begin
                    if (r_best.when > r_time) begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_CHK;
                    end else begin
                        r_fcnt[ci] <= f_cur + 1'b1;
                        r_j        <= r_best_idx;
                        r_state    <= S_HRD;
                    end
                end
                S_HRD: begin
                    // close the gap left by the moved entry
                    if ({1'b0, r_j} + 1'b1 < n_cur) begin
                        r_state <= S_HWR;
                    end else begin
                        r_pcnt[ci] <= n_cur - 1'b1;
                        r_state    <= S_CHK;
                    end
                end
                S_HWR: begin
                    r_j     <= r_j + 1'b1;
                    r_state <= S_HRD;
                end
                S_DONE: begin
                    if (!r_out_vld || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        res_full                = r_res;
        res_full.work_available = avail;
        res_full.any_pending    = (r_total != '0);
        res_full.total_count    = r_total;
        res_full.current_time   = r_time;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_vld || !i_out_stall)) begin
            r_out <= res_full;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    logic cnt_over;
    always_comb begin
        cnt_over = 1'b0;
        for (int k = 0; k < NC; k++) begin
            if (r_fcnt[k] > NB'(clctq_pkg::QUEUE_DEPTH)) cnt_over = 1'b1;
            if (r_pcnt[k] > NB'(clctq_pkg::QUEUE_DEPTH)) cnt_over = 1'b1;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n) !cnt_over)
        else $error("queue count beyond depth");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state != S_IDLE)
        else $error("request taken but engine stayed idle");
    a_fifo_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_we |-> f_cur < NB'(clctq_pkg::QUEUE_DEPTH))
        else $error("move into full ready queue");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_out_stall |=> r_out_vld)
        else $error("result lost while stalled");

endmodule

// File: rtl/clustered_timed_work_queue.sv
// Top level of the clustered timed work queue: config registers, front, engine.
// Depends on clctq_pkg, clctq_front and clctq_back.
//
// Usage: requests arrive on i_in_valid / o_in_stall carrying t_in_item; a transfer
// happens on a clock edge with valid high and stall low. Each request gives
// exactly one result on o_out_valid / i_out_stall (t_out_item), in order.
// A put goes to the pending store of a cluster picked from the random draw,
// a get pops a cluster's ready queue, a tick advances time and moves due work.
// Each division occupies the engine, which has a single shared divider. Every
// put, get and tick first runs one for the active cluster count; a get adds a
// second one, a put two more. A tick checks each active cluster in turn, scans
// its pending entries for the earliest due one and moves it, until none is due
// or the ready queue is full. Items are processed one at a time.
// A two-entry input queue takes new requests while the engine works.
// Reset (synchronous, active low) sets num_cores 8, cluster_size 2, time zero
// and empties all queues; store contents need no clearing.
// When the receiver stalls, the result is held and the engine waits.
// Config writes are always ready and must be issued only while idle.
module clustered_timed_work_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  clctq_pkg::t_in_item               i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output clctq_pkg::t_out_item              o_out_item,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [1:0]                        i_cfg_index,
    input  logic [clctq_pkg::REG_BITS-1:0]    i_cfg_data
);

    logic [clctq_pkg::REG_BITS-1:0] r_num_cores;
    logic [clctq_pkg::REG_BITS-1:0] r_cluster_size;
    clctq_pkg::t_front_out          front;
    logic                           pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cores    <= clctq_pkg::REG_BITS'(8);
            r_cluster_size <= clctq_pkg::REG_BITS'(2);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                clctq_pkg::CFG_NUM_CORES:    r_num_cores    <= i_cfg_data;
                clctq_pkg::CFG_CLUSTER_SIZE: r_cluster_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    clctq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_front    (front),
        .i_pop      (pop)
    );

    clctq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_front        (front),
        .o_pop          (pop),
        .i_num_cores    (r_num_cores),
        .i_cluster_size (r_cluster_size),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_item     (o_out_item)
    );

endmodule
